### sv/grid_best_first_path_search_top_macros.svh
// assertion helpers for the path search block
`ifndef GRID_BEST_FIRST_PATH_SEARCH_TOP_MACROS_SVH
`define GRID_BEST_FIRST_PATH_SEARCH_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define GBFS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GBFS_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/gbfs_pkg.sv
package gbfs_pkg;

  localparam int unsigned MaxWidth  = 32;
  localparam int unsigned MaxHeight = 32;
  localparam int unsigned Cells     = MaxWidth * MaxHeight;
  localparam int unsigned CellW     = $clog2(Cells);
  localparam int unsigned KeyW      = 6;
  localparam int unsigned Buckets   = 2 ** KeyW;

  // opcodes of an input transaction
  typedef enum logic [1:0] {
    OpWrRow  = 2'd0,
    OpSearch = 2'd1,
    OpStep   = 2'd2,
    OpNone   = 2'd3
  } op_e;

  // step directions
  typedef enum logic [1:0] {
    DirPx = 2'd0,
    DirMx = 2'd1,
    DirPy = 2'd2,
    DirMy = 2'd3
  } dir_e;

  // configuration register indexes
  localparam logic CfgGridWidth  = 1'b0;
  localparam logic CfgGridHeight = 1'b1;

  localparam logic [5:0] GridWidthRst  = 6'd29;
  localparam logic [5:0] GridHeightRst = 6'd27;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  row_index;
    logic [31:0] row_free_bits;
    logic [4:0]  start_x;
    logic [4:0]  start_y;
    logic [4:0]  goal_x;
    logic [4:0]  goal_y;
  } in_item_t;

  typedef struct packed {
    logic       path_found;
    logic [9:0] step_count;
    logic       step_valid;
    logic [1:0] step_direction;
    logic       last_step;
  } out_item_t;

  // result handoff from the search engine
  typedef struct packed {
    logic      valid;
    out_item_t data;
  } res_t;

endpackage

### sv/gbfs_core.sv
module gbfs_core import gbfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  in_item_t   item_i,
  input  logic [5:0] grid_w_i,
  input  logic [5:0] grid_h_i,
  input  logic       res_free_i,
  output logic       idle_o,
  output res_t       res_o
);

  typedef enum logic [15:0] {
    StIdle   = 16'h0001,
    StClr    = 16'h0002,
    StChkS   = 16'h0004,
    StChkG   = 16'h0008,
    StChkEnd = 16'h0010,
    StPushRd = 16'h0020,
    StPushWr = 16'h0040,
    StPop    = 16'h0080,
    StPopHt  = 16'h0100,
    StPopNx  = 16'h0200,
    StExp    = 16'h0400,
    StExpChk = 16'h0800,
    StTrRd   = 16'h1000,
    StTrWr   = 16'h2000,
    StStepRd = 16'h4000,
    StRes    = 16'h8000
  } state_e;

  typedef struct packed {
    logic vis;
    dir_e dir;
  } cell_t;

  typedef struct packed {
    logic [CellW-1:0] head;
    logic [CellW-1:0] tail;
  } ht_t;

  function automatic logic [KeyW-1:0] manh_dist(logic [CellW-1:0] c, logic [4:0] gx,
                                                logic [4:0] gy);
    logic [4:0] dx;
    logic [4:0] dy;
    dx = (c[4:0] > gx) ? c[4:0] - gx : gx - c[4:0];
    dy = (c[9:5] > gy) ? c[9:5] - gy : gy - c[9:5];
    return {1'b0, dx} + {1'b0, dy};
  endfunction

  state_e st_q, st_d;
  in_item_t item_q, item_d;
  logic [CellW-1:0] addr_q, addr_d;
  logic [CellW-1:0] cur_q, cur_d;
  dir_e dir_q, dir_d;
  logic [CellW-1:0] pc_q, pc_d;
  logic [KeyW-1:0] pk_q, pk_d;
  dir_e pd_q, pd_d;
  logic ret_q, ret_d;
  logic [Buckets-1:0] mask_q, mask_d;
  logic [KeyW-1:0] bkt_q, bkt_d;
  logic [CellW-1:0] tl_q, tl_d;
  logic [CellW-1:0] len_q, len_d;
  logic [CellW-1:0] rp_q, rp_d;
  logic [CellW-1:0] n_q, n_d;
  logic oks_q, oks_d;
  out_item_t res_q, res_d;

  // memory ports
  logic [4:0] fm_addr;
  logic fm_we;
  logic [31:0] fm_wd, fm_rq;
  logic [MaxHeight-1:0] fv_q;
  logic fv_rq;
  logic [31:0] fm_row;
  logic [CellW-1:0] cm_addr;
  logic cm_we;
  cell_t cm_wd, cm_rq;
  logic [CellW-1:0] nx_addr, nx_wd, nx_rq;
  logic nx_we;
  logic [KeyW-1:0] ht_addr;
  logic ht_we;
  ht_t ht_wd, ht_rq;
  logic [CellW-1:0] pm_addr;
  logic pm_we;
  dir_e pm_wd, pm_rq;

  logic [31:0] fm_mem [MaxHeight];
  cell_t cm_mem [Cells];
  logic [CellW-1:0] nx_mem [Cells];
  ht_t ht_mem [Buckets];
  dir_e pm_mem [Cells];

  logic [5:0] gw, gh;
  logic [CellW-1:0] start_c, goal_c;
  logic [KeyW-1:0] low_idx;
  logic [4:0] cx, cy, nbx, nby, px, py;
  logic nb_ok;
  logic ok_g;

  assign gw = (grid_w_i > 6'(MaxWidth)) ? 6'(MaxWidth) : grid_w_i;
  assign gh = (grid_h_i > 6'(MaxHeight)) ? 6'(MaxHeight) : grid_h_i;
  assign start_c = {item_q.start_y, item_q.start_x};
  assign goal_c = {item_q.goal_y, item_q.goal_x};
  assign fm_row = fm_rq & {32{fv_rq}};

  // lowest non-empty bucket
  always_comb begin
    low_idx = '0;
    for (int i = Buckets - 1; i >= 0; i--) begin
      if (mask_q[i]) low_idx = KeyW'(i);
    end
  end

  // neighbor of the expanded cell
  always_comb begin
    cx = cur_q[4:0];
    cy = cur_q[9:5];
    nbx = cx;
    nby = cy;
    nb_ok = 1'b0;
    unique case (dir_q)
      DirPx: begin
        nbx = cx + 5'd1;
        nb_ok = ({1'b0, cx} + 6'd1) < gw;
      end
      DirMx: begin
        nbx = cx - 5'd1;
        nb_ok = cx != 5'd0;
      end
      DirPy: begin
        nby = cy + 5'd1;
        nb_ok = ({1'b0, cy} + 6'd1) < gh;
      end
      DirMy: begin
        nby = cy - 5'd1;
        nb_ok = cy != 5'd0;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // predecessor on the traced path
  always_comb begin
    px = cur_q[4:0];
    py = cur_q[9:5];
    unique case (cm_rq.dir)
      DirPx: px = cur_q[4:0] - 5'd1;
      DirMx: px = cur_q[4:0] + 5'd1;
      DirPy: py = cur_q[9:5] - 5'd1;
      DirMy: py = cur_q[9:5] + 5'd1;
      default: px = cur_q[4:0];
    endcase
  end

  assign ok_g = ({1'b0, item_q.goal_x} < gw) && ({1'b0, item_q.goal_y} < gh) &&
                fm_row[item_q.goal_x];

  // sequencer
  always_comb begin
    st_d = st_q;
    item_d = item_q;
    addr_d = addr_q;
    cur_d = cur_q;
    dir_d = dir_q;
    pc_d = pc_q;
    pk_d = pk_q;
    pd_d = pd_q;
    ret_d = ret_q;
    mask_d = mask_q;
    bkt_d = bkt_q;
    tl_d = tl_q;
    len_d = len_q;
    rp_d = rp_q;
    n_d = n_q;
    oks_d = oks_q;
    res_d = res_q;
    fm_addr = item_q.start_y;
    fm_we = 1'b0;
    fm_wd = item_i.row_free_bits;
    cm_addr = pc_q;
    cm_we = 1'b0;
    cm_wd = '{vis: 1'b1, dir: pd_q};
    nx_addr = ht_rq.head;
    nx_we = 1'b0;
    nx_wd = pc_q;
    ht_addr = pk_q;
    ht_we = 1'b0;
    ht_wd = '{head: pc_q, tail: pc_q};
    pm_addr = n_q;
    pm_we = 1'b0;
    pm_wd = cm_rq.dir;

    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          item_d = item_i;
          res_d = '0;
          unique case (op_e'(item_i.op))
            OpWrRow: begin
              fm_we = 1'b1;
              fm_addr = item_i.row_index;
              st_d = StRes;
            end
            OpSearch: begin
              addr_d = '0;
              len_d = '0;
              rp_d = '0;
              mask_d = '0;
              st_d = StClr;
            end
            OpStep: begin
              if (rp_q < len_q) begin
                pm_addr = len_q - rp_q - CellW'(1);
                st_d = StStepRd;
              end else begin
                st_d = StRes;
              end
            end
            default: st_d = StRes;
          endcase
        end
      end
      // clear visited marks, one cell a cycle
      StClr: begin
        cm_we = 1'b1;
        cm_addr = addr_q;
        cm_wd = '{vis: 1'b0, dir: DirPx};
        addr_d = addr_q + CellW'(1);
        if (addr_q == CellW'(Cells - 1)) st_d = StChkS;
      end
      StChkS: begin
        fm_addr = item_q.start_y;
        st_d = StChkG;
      end
      StChkG: begin
        oks_d = ({1'b0, item_q.start_x} < gw) && ({1'b0, item_q.start_y} < gh) &&
                fm_row[item_q.start_x];
        fm_addr = item_q.goal_y;
        st_d = StChkEnd;
      end
      StChkEnd: begin
        if (!(oks_q && ok_g)) begin
          st_d = StRes;
        end else if (start_c == goal_c) begin
          res_d.path_found = 1'b1;
          st_d = StRes;
        end else begin
          pc_d = start_c;
          pk_d = manh_dist(start_c, item_q.goal_x, item_q.goal_y);
          pd_d = DirPx;
          ret_d = 1'b0;
          st_d = StPushRd;
        end
      end
      // mark visited and fetch the bucket ends
      StPushRd: begin
        cm_we = 1'b1;
        cm_addr = pc_q;
        ht_addr = pk_q;
        st_d = StPushWr;
      end
      StPushWr: begin
        ht_we = 1'b1;
        ht_addr = pk_q;
        if (!mask_q[pk_q]) begin
          ht_wd = '{head: pc_q, tail: pc_q};
          mask_d[pk_q] = 1'b1;
        end else begin
          ht_wd = '{head: ht_rq.head, tail: pc_q};
          nx_we = 1'b1;
          nx_addr = ht_rq.tail;
          nx_wd = pc_q;
        end
        if (!ret_q || dir_q == DirMy) begin
          st_d = StPop;
        end else begin
          dir_d = dir_e'(dir_q + 2'd1);
          st_d = StExp;
        end
      end
      StPop: begin
        if (mask_q == '0) begin
          st_d = StRes;
        end else begin
          bkt_d = low_idx;
          ht_addr = low_idx;
          st_d = StPopHt;
        end
      end
      StPopHt: begin
        cur_d = ht_rq.head;
        tl_d = ht_rq.tail;
        dir_d = DirPx;
        nx_addr = ht_rq.head;
        if (ht_rq.head == goal_c) begin
          n_d = '0;
          st_d = StTrRd;
        end else if (ht_rq.head == ht_rq.tail) begin
          mask_d[bkt_q] = 1'b0;
          st_d = StExp;
        end else begin
          st_d = StPopNx;
        end
      end
      StPopNx: begin
        ht_we = 1'b1;
        ht_addr = bkt_q;
        ht_wd = '{head: nx_rq, tail: tl_q};
        st_d = StExp;
      end
      // try one neighbor
      StExp: begin
        if (nb_ok) begin
          pc_d = {nby, nbx};
          fm_addr = nby;
          cm_addr = {nby, nbx};
          st_d = StExpChk;
        end else if (dir_q == DirMy) begin
          st_d = StPop;
        end else begin
          dir_d = dir_e'(dir_q + 2'd1);
        end
      end
      StExpChk: begin
        if (fm_row[pc_q[4:0]] && !cm_rq.vis) begin
          pk_d = manh_dist(pc_q, item_q.goal_x, item_q.goal_y);
          pd_d = dir_q;
          ret_d = 1'b1;
          st_d = StPushRd;
        end else if (dir_q == DirMy) begin
          st_d = StPop;
        end else begin
          dir_d = dir_e'(dir_q + 2'd1);
          st_d = StExp;
        end
      end
      // walk back from the goal, storing steps last first
      StTrRd: begin
        cm_addr = cur_q;
        if (cur_q == start_c) begin
          res_d.path_found = 1'b1;
          res_d.step_count = n_q;
          len_d = n_q;
          st_d = StRes;
        end else begin
          st_d = StTrWr;
        end
      end
      StTrWr: begin
        pm_we = 1'b1;
        pm_addr = n_q;
        pm_wd = cm_rq.dir;
        n_d = n_q + CellW'(1);
        cur_d = {py, px};
        st_d = StTrRd;
      end
      StStepRd: begin
        res_d.step_valid = 1'b1;
        res_d.step_direction = pm_rq;
        res_d.last_step = (rp_q + CellW'(1)) == len_q;
        rp_d = rp_q + CellW'(1);
        st_d = StRes;
      end
      StRes: begin
        if (res_free_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      mask_q <= '0;
      len_q <= '0;
      rp_q <= '0;
      ret_q <= 1'b0;
      dir_q <= DirPx;
      fv_q <= '0;
      fv_rq <= 1'b0;
    end else begin
      st_q <= st_d;
      mask_q <= mask_d;
      len_q <= len_d;
      rp_q <= rp_d;
      ret_q <= ret_d;
      dir_q <= dir_d;
      if (fm_we) fv_q[fm_addr] <= 1'b1;
      fv_rq <= fv_q[fm_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    addr_q <= addr_d;
    cur_q <= cur_d;
    pc_q <= pc_d;
    pk_q <= pk_d;
    pd_q <= pd_d;
    bkt_q <= bkt_d;
    tl_q <= tl_d;
    n_q <= n_d;
    oks_q <= oks_d;
    res_q <= res_d;
  end

  // free map rows
  always_ff @(posedge clk_i) begin
    if (fm_we) fm_mem[fm_addr] <= fm_wd;
    fm_rq <= fm_mem[fm_addr];
  end

  // visited mark and parent direction per cell
  always_ff @(posedge clk_i) begin
    if (cm_we) cm_mem[cm_addr] <= cm_wd;
    cm_rq <= cm_mem[cm_addr];
  end

  // bucket list links
  always_ff @(posedge clk_i) begin
    if (nx_we) nx_mem[nx_addr] <= nx_wd;
    nx_rq <= nx_mem[nx_addr];
  end

  // bucket head and tail
  always_ff @(posedge clk_i) begin
    if (ht_we) ht_mem[ht_addr] <= ht_wd;
    ht_rq <= ht_mem[ht_addr];
  end

  // path steps
  always_ff @(posedge clk_i) begin
    if (pm_we) pm_mem[pm_addr] <= pm_wd;
    pm_rq <= pm_mem[pm_addr];
  end

  assign idle_o = st_q == StIdle;
  assign res_o = '{valid: st_q == StRes, data: res_q};

endmodule

### sv/grid_best_first_path_search_top.sv
// Grid path search: greedy best-first search on a 4-connected grid.
// Input channel in_valid_i / in_stall_o / in_data_i carries one command per
// transaction: write a map row, start a search, or read the next path step.
// Output channel out_valid_o / out_stall_i / out_data_o returns exactly one
// result transaction per command, in order.
// Configuration: cfg_we_i writes cfg_data_i into grid width (index 0) or grid
// height (index 1); write only while no command is in flight.
// A search starts with a sweep that clears the visited marks of all 1024
// cells, then expands the dequeued cells neighbor by neighbor, and on
// reaching the goal traces the path back step by step. Every pass goes
// through single-port cell memories, one access each.
// One command is processed at a time; the next is taken as soon as the
// engine hands its result to the output register.
// Reset: map all blocked, no path stored, grid 29 x 27.
// A stalled receiver holds the result in the output register; the engine
// then waits with its next result and stalls the input.
`include "grid_best_first_path_search_top_macros.svh"

module grid_best_first_path_search_top import gbfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [5:0] cfg_data_i
);

  logic [5:0] gw_q, gh_q;
  logic core_idle;
  logic accept;
  logic res_free;
  res_t core_res;
  logic out_valid_q;
  out_item_t out_data_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= GridWidthRst;
      gh_q <= GridHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGridWidth: gw_q <= cfg_data_i;
        CfgGridHeight: gh_q <= cfg_data_i;
        default: gw_q <= gw_q;
      endcase
    end
  end

  assign in_stall_o = !core_idle;
  assign accept = in_valid_i && core_idle;
  assign res_free = !out_valid_q || !out_stall_i;

  gbfs_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .item_i     (in_data_i),
    .grid_w_i   (gw_q),
    .grid_h_i   (gh_q),
    .res_free_i (res_free),
    .idle_o     (core_idle),
    .res_o      (core_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res.valid && res_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res.valid && res_free) out_data_q <= core_res.data;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  `GBFS_ASSERT_NXT(a_busy_after_accept, accept, in_stall_o, "engine idle after accept")
  `GBFS_ASSERT_NXT(a_result_loaded, core_res.valid && res_free, out_valid_q,
                   "handed result not in output register")
  `GBFS_ASSERT_NOW(a_result_source, $rose(out_valid_q), $past(core_res.valid),
                   "output valid without engine result")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import gbfs_pkg::*;

  localparam int unsigned IdleLimit = 60000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;
  logic      cfg_we_i;
  logic      cfg_idx_i;
  logic [5:0] cfg_data_i;

  grid_best_first_path_search_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow copy of the block state
  logic [31:0] free_rows [MaxHeight];
  logic [5:0]  grid_w;
  logic [5:0]  grid_h;
  logic [1:0]  route [Cells];
  int          route_len;
  int          route_ptr;

  out_item_t   result_q [$];
  int          errors;
  int          idle_cycles;
  bit          calm;
  bit          pin_now;
  out_item_t   pin_val;
  bit          out_took;
  int          hold_cnt;

  typedef struct {
    in_item_t  item;
    bit        pin;
    out_item_t want;
  } stim_row_t;

  stim_row_t directed [$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp_dim(logic [5:0] v, int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  // greedy best-first search over the shadow map, fills route
  function automatic bit find_route(int sx, int sy, int gx, int gy);
    int        gw;
    int        gh;
    bit        seen [Cells];
    logic [1:0] par [Cells];
    int        qcell [Cells];
    int        qkey [Cells];
    bit        qdone [Cells];
    int        pushes;
    int        best;
    int        cur;
    int        cx;
    int        cy;
    int        nx;
    int        ny;
    int        nc;
    int        n;
    bit        hit;
    logic [1:0] tmp [Cells];
    gw = clamp_dim(grid_w, MaxWidth);
    gh = clamp_dim(grid_h, MaxHeight);
    route_len = 0;
    route_ptr = 0;
    hit = 1'b0;
    pushes = 0;
    foreach (seen[i]) seen[i] = 1'b0;
    if (sx >= gw || sy >= gh || gx >= gw || gy >= gh) return 1'b0;
    if (!free_rows[sy][sx] || !free_rows[gy][gx]) return 1'b0;
    seen[sy * MaxWidth + sx] = 1'b1;
    qcell[0] = sy * MaxWidth + sx;
    qkey[0] = (sx > gx ? sx - gx : gx - sx) + (sy > gy ? sy - gy : gy - sy);
    qdone[0] = 1'b0;
    pushes = 1;
    forever begin
      best = -1;
      for (int i = 0; i < pushes; i++) begin
        if (!qdone[i] && (best < 0 || qkey[i] < qkey[best])) best = i;
      end
      if (best < 0) break;
      qdone[best] = 1'b1;
      cur = qcell[best];
      if (cur == gy * MaxWidth + gx) begin
        hit = 1'b1;
        break;
      end
      cx = cur % MaxWidth;
      cy = cur / MaxWidth;
      for (int d = 0; d < 4; d++) begin
        nx = cx + (d == DirPx ? 1 : d == DirMx ? -1 : 0);
        ny = cy + (d == DirPy ? 1 : d == DirMy ? -1 : 0);
        if (nx < 0 || ny < 0 || nx >= gw || ny >= gh) continue;
        if (!free_rows[ny][nx]) continue;
        nc = ny * MaxWidth + nx;
        if (seen[nc]) continue;
        seen[nc] = 1'b1;
        par[nc] = 2'(d);
        if (pushes < Cells) begin
          qcell[pushes] = nc;
          qkey[pushes] = (nx > gx ? nx - gx : gx - nx) + (ny > gy ? ny - gy : gy - ny);
          qdone[pushes] = 1'b0;
          pushes++;
        end
      end
    end
    if (!hit) return 1'b0;
    // walk parents back to the start, then reverse
    n = 0;
    cur = gy * MaxWidth + gx;
    while (cur != sy * MaxWidth + sx && n < Cells) begin
      tmp[n] = par[cur];
      cx = cur % MaxWidth - (par[cur] == DirPx ? 1 : par[cur] == DirMx ? -1 : 0);
      cy = cur / MaxWidth - (par[cur] == DirPy ? 1 : par[cur] == DirMy ? -1 : 0);
      n++;
      cur = cy * MaxWidth + cx;
    end
    for (int i = 0; i < n; i++) route[i] = tmp[n - 1 - i];
    route_len = n;
    return 1'b1;
  endfunction

  // expected result of one command, updates the shadow state
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    bit        ok;
    r = '0;
    case (op_e'(it.op))
      OpWrRow: free_rows[it.row_index] = it.row_free_bits;
      OpSearch: begin
        ok = find_route(it.start_x, it.start_y, it.goal_x, it.goal_y);
        r.path_found = ok;
        r.step_count = (route_len > 1023) ? 10'd1023 : 10'(route_len);
      end
      OpStep: begin
        if (route_ptr < route_len) begin
          r.step_valid = 1'b1;
          r.step_direction = route[route_ptr];
          r.last_step = (route_ptr + 1 == route_len);
          route_ptr++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_cmd(op_e op, int row, logic [31:0] bits,
                                        int sx, int sy, int gx, int gy);
    in_item_t it;
    it.op = op;
    it.row_index = 5'(row);
    it.row_free_bits = bits;
    it.start_x = 5'(sx);
    it.start_y = 5'(sy);
    it.goal_x = 5'(gx);
    it.goal_y = 5'(gy);
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit pin, out_item_t want);
    stim_row_t s;
    s.item = it;
    s.pin = pin;
    s.want = want;
    directed.push_back(s);
  endfunction

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk_i) begin
    out_item_t e;
    out_item_t p;
    if (rst_ni) begin
      idle_cycles = idle_cycles + 1;
      if (in_valid_i && !in_stall_o) begin
        idle_cycles = 0;
        p = predict_result(in_data_i);
        result_q.push_back(pin_now ? pin_val : p);
      end
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        out_took = 1'b1;
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          e = result_q.pop_front();
          if (out_data_o.path_found !== e.path_found ||
              out_data_o.step_count !== e.step_count ||
              out_data_o.step_valid !== e.step_valid ||
              out_data_o.step_direction !== e.step_direction ||
              out_data_o.last_step !== e.last_step) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", e, out_data_o);
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) begin
        hold_cnt = calm ? 0 : $urandom_range(0, 3);
        out_took = 1'b0;
      end
      out_stall_i = (hold_cnt != 0);
      if (hold_cnt != 0) hold_cnt--;
    end
  end

  task automatic send_cmd(in_item_t it, bit pin, out_item_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = it;
    pin_now = pin;
    pin_val = want;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    pin_now = 1'b0;
  endtask

  task automatic quiesce();
    in_valid_i = 1'b0;
    while (result_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [5:0] val);
    quiesce();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    if (idx == CfgGridWidth) grid_w = val;
    else grid_h = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic pick_cell(int gw, int gh, output int x, output int y);
    if (gw > 0 && gh > 0 && $urandom_range(0, 9) < 8) begin
      x = $urandom_range(0, gw - 1);
      y = $urandom_range(0, gh - 1);
    end else begin
      x = $urandom_range(0, 31);
      y = $urandom_range(0, 31);
    end
  endtask

  // one random phase under a given grid size, rewriting the first rows
  task automatic run_phase(logic [5:0] w, logic [5:0] h, int searches, int nrows);
    int        gw;
    int        gh;
    int        sx;
    int        sy;
    int        gx;
    int        gy;
    int        reads;
    logic [31:0] bits;
    out_item_t z;
    z = '0;
    write_cfg(CfgGridWidth, w);
    write_cfg(CfgGridHeight, h);
    calm = ($urandom_range(0, 3) == 0);
    gw = clamp_dim(w, MaxWidth);
    gh = clamp_dim(h, MaxHeight);
    for (int r = 0; r < nrows; r++) begin
      bits = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : ($urandom | $urandom);
      send_cmd(make_cmd(OpWrRow, r, bits, 0, 0, 0, 0), 1'b0, z);
    end
    for (int s = 0; s < searches; s++) begin
      pick_cell(gw, gh, sx, sy);
      pick_cell(gw, gh, gx, gy);
      send_cmd(make_cmd(OpSearch, $urandom_range(0, 31), $urandom, sx, sy, gx, gy), 1'b0, z);
      reads = (route_len + 1 > 6 && $urandom_range(0, 2) != 0) ? 6 : route_len + 1;
      for (int k = 0; k < reads; k++) begin
        send_cmd(make_cmd(OpStep, $urandom_range(0, 31), $urandom, $urandom_range(0, 31),
                          $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 31)), 1'b0, z);
      end
      // noise: unused op or a stray row write
      if ($urandom_range(0, 3) == 0) begin
        send_cmd(make_cmd(op_e'($urandom_range(0, 1) ? OpNone : OpWrRow),
                          $urandom_range(0, 31), $urandom | $urandom, 0, 0, 0, 0),
                 1'b0, z);
      end
    end
  endtask

  // stimulus
  initial begin
    out_item_t z;
    out_item_t hit0;
    z = '0;
    hit0 = '0;
    hit0.path_found = 1'b1;
    errors = 0;
    idle_cycles = 0;
    calm = 1'b0;
    pin_now = 1'b0;
    pin_val = '0;
    out_took = 1'b0;
    hold_cnt = 0;
    route_len = 0;
    route_ptr = 0;
    grid_w = GridWidthRst;
    grid_h = GridHeightRst;
    foreach (free_rows[i]) free_rows[i] = '0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgGridWidth;
    cfg_data_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, default grid 29 x 27
    add_row(make_cmd(OpSearch, 0, 0, 0, 0, 1, 0), 1'b1, z);
    add_row(make_cmd(OpStep, 0, 0, 0, 0, 0, 0), 1'b1, z);
    add_row(make_cmd(OpNone, 31, 32'hFFFF_FFFF, 31, 31, 31, 31), 1'b1, z);
    add_row(make_cmd(OpWrRow, 0, 32'hFFFF_FFFF, 0, 0, 0, 0), 1'b1, z);
    add_row(make_cmd(OpWrRow, 31, 32'hFFFF_FFFF, 0, 0, 0, 0), 1'b1, z);
    add_row(make_cmd(OpWrRow, 1, 32'h5555_5555, 0, 0, 0, 0), 1'b1, z);
    add_row(make_cmd(OpSearch, 0, 0, 0, 0, 28, 0), 1'b0, z);
    add_row(make_cmd(OpStep, 0, 0, 0, 0, 0, 0), 1'b0, z);
    add_row(make_cmd(OpStep, 0, 0, 0, 0, 0, 0), 1'b0, z);
    add_row(make_cmd(OpSearch, 0, 0, 3, 0, 3, 0), 1'b1, hit0);
    add_row(make_cmd(OpStep, 0, 0, 0, 0, 0, 0), 1'b1, z);
    add_row(make_cmd(OpSearch, 0, 0, 29, 0, 0, 0), 1'b1, z);
    add_row(make_cmd(OpSearch, 0, 0, 0, 0, 1, 1), 1'b1, z);
    add_row(make_cmd(OpSearch, 0, 0, 0, 31, 0, 0), 1'b1, z);
    add_row(make_cmd(OpSearch, 0, 0, 0, 1, 4, 0), 1'b0, z);
    for (int k = 0; k < 6; k++) add_row(make_cmd(OpStep, 0, 0, 0, 0, 0, 0), 1'b0, z);
    add_row(make_cmd(OpSearch, 0, 0, 4, 0, 2, 1), 1'b0, z);
    add_row(make_cmd(OpStep, 0, 0, 0, 0, 0, 0), 1'b0, z);
    foreach (directed[i]) send_cmd(directed[i].item, directed[i].pin, directed[i].want);

    // random phases across grid sizes, extremes included
    run_phase(6'd29, 6'd27, 1, 27);
    run_phase(6'd0, 6'd5, 2, 2);
    run_phase(6'd5, 6'd0, 1, 2);
    run_phase(6'd1, 6'd1, 2, 1);
    run_phase(6'd4, 6'd3, 2, 3);
    run_phase(6'd63, 6'd63, 2, 4);
    run_phase(6'd8, 6'd6, 1, 4);
    run_phase(6'd32, 6'd32, 1, 4);
    run_phase(6'd6, 6'd40, 2, 4);

    // drain and finish
    quiesce();
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
